[sv/crtsh_pkg.sv]
// Shared types, constants and helper functions for the CRT scanline pixel shader.
`timescale 1ns / 1ps
`default_nettype none
package crtsh_pkg;

  localparam int unsigned PIPE_DEPTH = 7;

  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DATA_W = 18;

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FORMAT = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_XSTEP  = 3'd4;
  localparam logic [IDX_W-1:0] REG_YSTEP  = 3'd5;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_CRT = 2'd2;

  localparam logic [1:0] FMT_565  = 2'd0;
  localparam logic [1:0] FMT_1555 = 2'd1;
  localparam logic [1:0] FMT_8888 = 2'd2;
  localparam logic [1:0] FMT_888  = 2'd3;

  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam logic [16:0] SCAN_ODD  = 17'd44564;
  localparam logic [16:0] VIG_FLOOR = 17'd40632;
  localparam logic [15:0] VIG_SAT   = 16'd24904;   // one minus the floor
  localparam logic [13:0] VIG_COEF  = 14'd11796;
  localparam logic [7:0]  DIM_MUL   = 8'd225;
  localparam logic [16:0] ROUND_HALF = 17'd128;
  localparam logic [36:0] ROUND_Q16 = 37'd32768;

  localparam logic [12:0] REST_WIDTH  = 13'd320;
  localparam logic [12:0] REST_HEIGHT = 13'd240;
  localparam logic [17:0] REST_XSTEP  = 18'd411;
  localparam logic [17:0] REST_YSTEP  = 18'd548;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  fmt;
    logic [12:0] width;
    logic [12:0] height;
    logic [17:0] x_step;
    logic [17:0] y_step;
  } cfg_t;

  // column mod 3 by digit folding (4 == 1 mod 3)
  function automatic logic [1:0] mod3_12(input logic [11:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
    s2 = 3'(s1[4]) + 3'(s1[3:2]) + 3'(s1[1:0]);
    s3 = 3'(s2[2]) + 3'(s2[1:0]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

  function automatic logic [7:0] scale_ch(input logic [7:0] v, input logic [8:0] g,
                                          input logic [7:0] maxv);
    logic [16:0] p;
    logic [8:0]  q;
    p = 17'(v) * 17'(g) + ROUND_HALF;
    q = p[16:8];
    return (q > {1'b0, maxv}) ? maxv : q[7:0];
  endfunction

endpackage
`default_nettype wire

[sv/crtsh_gain.sv]
// Pipelined gain path: normalized coordinates, vignette, scanline gain, dimmed gain.
`timescale 1ns / 1ps
`default_nettype none
module crtsh_gain (
  input  wire logic                              clk,
  input  wire logic [crtsh_pkg::PIPE_DEPTH-1:0]  en,
  input  wire crtsh_pkg::cfg_t                   cfg,
  input  wire logic [11:0]                       col,
  input  wire logic [11:0]                       row,
  output logic [8:0]                             gain,
  output logic [8:0]                             dim
);
  import crtsh_pkg::*;

  logic [29:0] px_r, py_r;
  logic [17:0] ax_r, ay_r;
  logic [35:0] sqx_r, sqy_r;
  logic [17:0] rad_r;
  logic [16:0] vig_r;
  logic [8:0]  g6_r, g7_r, dim7_r;
  logic [4:0]  odd_r;

  logic [17:0] ax_nxt, ay_nxt;
  logic [17:0] rad_nxt;
  logic [16:0] vig_nxt;
  logic [8:0]  g6_nxt, dim7_nxt;

  function automatic logic [17:0] norm_abs(input logic [29:0] p, input logic [12:0] size);
    logic [29:0] d;
    d = (p >= 30'(Q16_ONE)) ? p - 30'(Q16_ONE) : 30'(Q16_ONE) - p;
    if (size <= 13'd1) begin
      return '0;
    end
    // beyond 2^18 the vignette is at its floor anyway
    return (|d[29:18]) ? '1 : d[17:0];
  endfunction

  logic [36:0] sum_w;
  logic [20:0] rr_w;
  logic [31:0] prod_w;
  logic [15:0] sub_w;
  logic [16:0] scan_w;
  logic [33:0] fac_w;
  logic [16:0] fac16_w;
  logic [16:0] dimp_w;

  always_comb begin
    ax_nxt  = norm_abs(px_r, cfg.width);
    ay_nxt  = norm_abs(py_r, cfg.height);
    sum_w   = 37'(sqx_r) + 37'(sqy_r) + ROUND_Q16;
    rr_w    = sum_w[36:16];
    rad_nxt = (|rr_w[20:18]) ? '1 : rr_w[17:0];
    prod_w  = 32'(rad_r) * 32'(VIG_COEF);
    sub_w   = prod_w[31:16];
    vig_nxt = (sub_w >= VIG_SAT) ? VIG_FLOOR : Q16_ONE - 17'(sub_w);
    scan_w  = odd_r[4] ? SCAN_ODD : Q16_ONE;
    fac_w   = 34'(scan_w) * 34'(vig_r);
    fac16_w = (cfg.mode == MODE_CRT) ? fac_w[32:16] : scan_w;
    g6_nxt  = fac16_w[16:8];
    dimp_w  = 17'(g6_r) * 17'(DIM_MUL);
    dim7_nxt = dimp_w[16:8];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r     <= 30'(col) * 30'(cfg.x_step);
      py_r     <= 30'(row) * 30'(cfg.y_step);
      odd_r[0] <= row[0];
    end
    if (en[1]) begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      odd_r[1] <= odd_r[0];
    end
    if (en[2]) begin
      sqx_r    <= 36'(ax_r) * 36'(ax_r);
      sqy_r    <= 36'(ay_r) * 36'(ay_r);
      odd_r[2] <= odd_r[1];
    end
    if (en[3]) begin
      rad_r    <= rad_nxt;
      odd_r[3] <= odd_r[2];
    end
    if (en[4]) begin
      vig_r    <= vig_nxt;
      odd_r[4] <= odd_r[3];
    end
    if (en[5]) begin
      g6_r <= g6_nxt;
    end
    if (en[6]) begin
      g7_r   <= g6_r;
      dim7_r <= dim7_nxt;
    end
  end

  assign gain = g7_r;
  assign dim  = dim7_r;

endmodule
`default_nettype wire

[sv/crt_scanline_pixel_shader.sv]
// Top level of the CRT scanline pixel shader: config registers, pipeline control, channel scaling.
//
//  channel | ports                         | payload
//  in      | in_tvalid/in_tready/in_tdata  | pixel_in[31:0], col[43:32], row[55:44]
//  out     | out_tvalid/out_tready/out_tdata | pixel_out[31:0]
//  cfg     | cfg_valid/cfg_ready/cfg_index/cfg_data | register index, write data
//
// One item per cycle sustained while out_tready holds; 7 gain stages, then the channel scaler.
// The 18x18 squaring and 17x17 gain multiplies each sit in a stage of their own.
// rst_n clears all stage valids and loads the register reset values; cfg is always ready.
// A stall at out_tready fills the bubbles first, then holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none
module crt_scanline_pixel_shader (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [55:0]                    in_tdata,    // pixel_in, col, row
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [31:0]                         out_tdata,   // pixel_out
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [crtsh_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [crtsh_pkg::DATA_W-1:0]   cfg_data
);
  import crtsh_pkg::*;

  localparam int unsigned LAST = PIPE_DEPTH - 1;

  cfg_t cfg_r;

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] rdy;
  logic                  rdy_out;
  logic [31:0]           pix_r  [PIPE_DEPTH];
  logic [1:0]            lane_r [PIPE_DEPTH];
  logic                  out_valid_r;
  logic [31:0]           out_data_r;

  logic [31:0] pix_nxt;
  logic [31:0] res_nxt;
  logic [8:0]  gain, dim;
  logic [8:0]  g0, g1, g2;
  logic        crt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_OFF;
      cfg_r.fmt    <= FMT_565;
      cfg_r.width  <= REST_WIDTH;
      cfg_r.height <= REST_HEIGHT;
      cfg_r.x_step <= REST_XSTEP;
      cfg_r.y_step <= REST_YSTEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   cfg_r.mode   <= cfg_data[1:0];
        REG_FORMAT: cfg_r.fmt    <= cfg_data[1:0];
        REG_WIDTH:  cfg_r.width  <= cfg_data[12:0];
        REG_HEIGHT: cfg_r.height <= cfg_data[12:0];
        REG_XSTEP:  cfg_r.x_step <= cfg_data;
        REG_YSTEP:  cfg_r.y_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // ready ripples back through empty stages
  always_comb begin
    rdy_out   = !out_valid_r || out_tready;
    rdy[LAST] = !v_r[LAST] || rdy_out;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_comb begin
    case (cfg_r.fmt)
      FMT_565:  pix_nxt = {16'h0, in_tdata[15:0]};
      FMT_1555: pix_nxt = {16'h0, in_tdata[14:5], 1'b0, in_tdata[4:0]};
      FMT_888:  pix_nxt = {8'h0, in_tdata[23:0]};
      default:  pix_nxt = in_tdata[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy_out) begin
        out_valid_r <= v_r[LAST];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pix_r[0]  <= pix_nxt;
      lane_r[0] <= mod3_12(in_tdata[43:32]);
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (rdy[k]) begin
        pix_r[k]  <= pix_r[k-1];
        lane_r[k] <= lane_r[k-1];
      end
    end
    if (rdy_out) begin
      out_data_r <= res_nxt;
    end
  end

  crtsh_gain u_gain (
    .clk  (clk),
    .en   (rdy),
    .cfg  (cfg_r),
    .col  (in_tdata[43:32]),
    .row  (in_tdata[55:44]),
    .gain (gain),
    .dim  (dim)
  );

  always_comb begin
    crt = (cfg_r.mode == MODE_CRT);
    g0  = (crt && lane_r[LAST] != 2'd0) ? dim : gain;
    g1  = (crt && lane_r[LAST] != 2'd1) ? dim : gain;
    g2  = (crt && lane_r[LAST] != 2'd2) ? dim : gain;
    if (cfg_r.mode == MODE_OFF) begin
      res_nxt = pix_r[LAST];
    end else begin
      case (cfg_r.fmt)
        FMT_8888: res_nxt = {pix_r[LAST][31:24],
                             scale_ch(pix_r[LAST][23:16], g0, 8'hFF),
                             scale_ch(pix_r[LAST][15:8],  g1, 8'hFF),
                             scale_ch(pix_r[LAST][7:0],   g2, 8'hFF)};
        FMT_888:  res_nxt = {8'h0,
                             scale_ch(pix_r[LAST][23:16], g2, 8'hFF),
                             scale_ch(pix_r[LAST][15:8],  g1, 8'hFF),
                             scale_ch(pix_r[LAST][7:0],   g0, 8'hFF)};
        default: begin
          logic [7:0] r8, gr8, b8;
          r8  = scale_ch({3'b0, pix_r[LAST][15:11]}, g0, 8'h1F);
          gr8 = scale_ch({2'b0, pix_r[LAST][10:5]},  g1, 8'h3F);
          b8  = scale_ch({3'b0, pix_r[LAST][4:0]},   g2, 8'h1F);
          res_nxt = {16'h0, r8[4:0], gr8[5:0], b8[4:0]};
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid && v_r == '0)
    else $error("pipeline valid survived reset");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && (&v_r)) |-> !in_tready)
    else $error("input accepted into a full stalled pipeline");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && !rdy[LAST]) |=> v_r[LAST] && $stable(pix_r[LAST]))
    else $error("stalled last stage lost its item");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] |-> (gain <= 9'd256) && (dim <= gain))
    else $error("gain out of range");

endmodule
`default_nettype wire

[tb/crt_scanline_pixel_shader_checker.sv]
// Scoreboard for the CRT scanline pixel shader: predicts each shaded pixel and compares.
`timescale 1ns / 1ps
module crt_scanline_pixel_shader_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [55:0] in_tdata,    // pixel_in, col, row
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,   // pixel_out
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [crtsh_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [crtsh_pkg::DATA_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending_count
);
  import crtsh_pkg::*;

  localparam logic [63:0] GAIN_UNITY   = 64'd65536;
  localparam logic [63:0] GAIN_ODD_ROW = 64'd44564;
  localparam logic [63:0] VIG_MIN      = 64'd40632;
  localparam logic [63:0] VIG_K        = 64'd11796;
  localparam logic [63:0] HALF_Q16     = 64'd32768;
  localparam logic [16:0] DIM_K        = 17'd225;
  localparam logic [16:0] HALF_Q8      = 17'd128;

  cfg_t        shader_cfg;
  logic [31:0] shaded_q[$];
  logic [31:0] want_pixel;

  // |pos*step - 1.0| in Q16; a frame side of one or less pins the coordinate to the center
  function automatic logic [63:0] center_offset(input logic [11:0] pos, input logic [17:0] step,
                                                input logic [12:0] side);
    logic [63:0] p;
    if (side <= 13'd1) return 64'd0;
    p = 64'(pos) * 64'(step);
    return (p >= GAIN_UNITY) ? p - GAIN_UNITY : GAIN_UNITY - p;
  endfunction

  function automatic logic [7:0] scaled_channel(input logic [7:0] v, input logic [8:0] gain,
                                                input logic [7:0] top);
    logic [16:0] p;
    p = 17'(v) * 17'(gain) + HALF_Q8;
    return (p[16:8] > 9'(top)) ? top : p[15:8];
  endfunction

  function automatic logic [31:0] shade_pixel(input cfg_t c, input logic [31:0] raw,
                                              input logic [11:0] col, input logic [11:0] row);
    logic [31:0] pix;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] radius;
    logic [63:0] sub;
    logic [63:0] vig;
    logic [63:0] factor;
    logic [8:0]  g;
    logic [8:0]  dim;
    logic [1:0]  lane;
    logic        crt;
    logic [8:0]  lane_gain [3];
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    pix = raw;
    if (c.fmt == FMT_565) pix = {16'd0, raw[15:0]};
    else if (c.fmt == FMT_1555) pix = {16'd0, raw[14:5], 1'b0, raw[4:0]};
    else if (c.fmt == FMT_888) pix = {8'd0, raw[23:0]};
    if (c.mode == MODE_OFF) return pix;

    crt = (c.mode == MODE_CRT);
    factor = row[0] ? GAIN_ODD_ROW : GAIN_UNITY;
    if (crt) begin
      ax = center_offset(col, c.x_step, c.width);
      ay = center_offset(row, c.y_step, c.height);
      radius = (ax * ax + ay * ay + HALF_Q16) >> 16;
      sub = (radius * VIG_K) >> 16;
      vig = (sub >= GAIN_UNITY - VIG_MIN) ? VIG_MIN : GAIN_UNITY - sub;
      factor = (factor * vig) >> 16;
    end
    if (factor > GAIN_UNITY) factor = GAIN_UNITY;
    g = factor[16:8];
    dim = 9'((17'(g) * DIM_K) >> 8);
    lane = 2'(col % 12'd3);
    for (int k = 0; k < 3; k++) lane_gain[k] = (crt && lane != 2'(k)) ? dim : g;

    if (c.fmt == FMT_565 || c.fmt == FMT_1555) begin
      c0 = scaled_channel({3'd0, pix[15:11]}, lane_gain[0], 8'h1f);
      c1 = scaled_channel({2'd0, pix[10:5]}, lane_gain[1], 8'h3f);
      c2 = scaled_channel({3'd0, pix[4:0]}, lane_gain[2], 8'h1f);
      return {16'd0, c0[4:0], c1[5:0], c2[4:0]};
    end else if (c.fmt == FMT_8888) begin
      c0 = scaled_channel(pix[23:16], lane_gain[0], 8'hff);
      c1 = scaled_channel(pix[15:8], lane_gain[1], 8'hff);
      c2 = scaled_channel(pix[7:0], lane_gain[2], 8'hff);
      return {pix[31:24], c0, c1, c2};
    end
    // RGB888 bytes: byte0 follows the first grille lane
    c0 = scaled_channel(pix[7:0], lane_gain[0], 8'hff);
    c1 = scaled_channel(pix[15:8], lane_gain[1], 8'hff);
    c2 = scaled_channel(pix[23:16], lane_gain[2], 8'hff);
    return {8'd0, c2, c1, c0};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shader_cfg.mode   = MODE_OFF;
      shader_cfg.fmt    = FMT_565;
      shader_cfg.width  = 13'd320;
      shader_cfg.height = 13'd240;
      shader_cfg.x_step = 18'd411;
      shader_cfg.y_step = 18'd548;
      shaded_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (shaded_q.size() == 0) begin
          $error("pixel_out: unexpected item, expected none, actual %08h", out_tdata);
          fail_count++;
        end else begin
          want_pixel = shaded_q.pop_front();
          if (want_pixel !== out_tdata) begin
            $error("pixel_out mismatch: expected %08h, actual %08h", want_pixel, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        shaded_q.push_back(shade_pixel(shader_cfg, in_tdata[31:0], in_tdata[43:32],
                                       in_tdata[55:44]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   shader_cfg.mode   = cfg_data[1:0];
          REG_FORMAT: shader_cfg.fmt    = cfg_data[1:0];
          REG_WIDTH:  shader_cfg.width  = cfg_data[12:0];
          REG_HEIGHT: shader_cfg.height = cfg_data[12:0];
          REG_XSTEP:  shader_cfg.x_step = cfg_data[17:0];
          REG_YSTEP:  shader_cfg.y_step = cfg_data[17:0];
          default: ;
        endcase
      end
      pending_count = shaded_q.size();
    end
  end

endmodule

[tb/crt_scanline_pixel_shader_tb.sv]
// Testbench top for the CRT scanline pixel shader: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module crt_scanline_pixel_shader_tb;
  import crtsh_pkg::*;

  localparam logic [1:0]       MODE_SCAN  = 2'd1;
  localparam logic [1:0]       MODE_SPARE = 2'd3;   // undefined, behaves as scanlines
  localparam logic [IDX_W-1:0] REG_SPARE0 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE1 = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [55:0]       in_tdata;    // pixel_in[31:0], col[43:32], row[55:44]
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;   // pixel_out[31:0]
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  logic in_took;
  logic cfg_took;
  int   fail_count;
  int   pending_count;
  int   tx_idle_pct = 34;
  int   rx_stall_pct = 34;

  crt_scanline_pixel_shader u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  crt_scanline_pixel_shader_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_took  <= in_tvalid && in_tready;
    cfg_took <= cfg_valid && cfg_ready;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic push_pixel(input logic [31:0] pix, input logic [11:0] col,
                            input logic [11:0] row);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {row, col, pix};
    do @(negedge clk); while (!in_took);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [1:0] mode, input logic [1:0] fmt,
                               input logic [17:0] w, input logic [17:0] h,
                               input logic [17:0] xs, input logic [17:0] ys);
    drain_results();
    write_reg(REG_MODE, 18'(mode));
    write_reg(REG_FORMAT, 18'(fmt));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_XSTEP, xs);
    write_reg(REG_YSTEP, ys);
  endtask

  initial begin
    #400000;
    $display("** crt_scanline_pixel_shader: FAILED **");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: pass-through, upper bits dropped
    push_pixel(32'hffffffff, 12'd0, 12'd0);
    push_pixel(32'h00000000, 12'd4095, 12'd4095);

    // full CRT on the reset geometry: corners, center, each grille lane, outside frame
    apply_setting(MODE_CRT, FMT_565, 18'd320, 18'd240, 18'd411, 18'd548);
    push_pixel(32'h0000ffff, 12'd0, 12'd0);
    push_pixel(32'h0000ffff, 12'd319, 12'd239);
    push_pixel(32'h0000ffff, 12'd160, 12'd120);
    push_pixel(32'h0000ffff, 12'd1, 12'd121);
    push_pixel(32'h0000ffff, 12'd2, 12'd120);
    push_pixel(32'hffffffff, 12'd4095, 12'd4095);

    // one-pixel frame pins the vignette to the center
    apply_setting(MODE_CRT, FMT_1555, 18'd1, 18'd1, 18'd0, 18'd0);
    push_pixel(32'h0000ffff, 12'd5, 12'd6);
    push_pixel(32'h0000aaaa, 12'd7, 12'd3);

    apply_setting(MODE_CRT, FMT_8888, 18'd4096, 18'd4096, 18'd32, 18'd32);
    push_pixel(32'hffffffff, 12'd0, 12'd4095);
    push_pixel(32'h80ff7f01, 12'd2048, 12'd2047);

    // oversize and zero sizes, extreme steps
    apply_setting(MODE_SCAN, FMT_888, 18'd8191, 18'd0, 18'h3ffff, 18'd131072);
    push_pixel(32'hffffffff, 12'd0, 12'd1);
    push_pixel(32'h00ffffff, 12'd3, 12'd0);

    apply_setting(MODE_SPARE, FMT_8888, 18'd0, 18'd8191, 18'd0, 18'h3ffff);
    push_pixel(32'hffffffff, 12'd1, 12'd1);
    push_pixel(32'h12345678, 12'd2, 12'd2);

    apply_setting(MODE_OFF, FMT_1555, 18'd320, 18'd240, 18'd411, 18'd548);
    push_pixel(32'hffffffff, 12'd0, 12'd0);
    push_pixel(32'h00007fff, 12'd1, 12'd1);

    drain_results();
    write_reg(REG_SPARE0, 18'($urandom));
    write_reg(REG_SPARE1, 18'($urandom));
    apply_setting(MODE_CRT, FMT_888, 18'd2, 18'd2, 18'd131072, 18'd131072);
    push_pixel(32'hffffffff, 12'd1, 12'd1);
    push_pixel(32'hff808080, 12'd0, 12'd0);

    // random phases over every mode and format
    for (int p = 0; p < 16; p++) begin
      int          kind;
      int          col_lim;
      int          row_lim;
      logic [17:0] w;
      logic [17:0] h;
      logic [17:0] xs;
      logic [17:0] ys;
      kind = $urandom_range(0, 7);
      case (kind)
        0: begin
          w  = 18'd1;
          h  = 18'd1;
          xs = 18'($urandom);
          ys = 18'($urandom);
        end
        1: begin
          w  = 18'd4096;
          h  = 18'd4096;
          xs = 18'd32;
          ys = 18'd32;
        end
        2: begin
          w  = 18'($urandom);
          h  = 18'($urandom);
          xs = 18'($urandom);
          ys = 18'($urandom);
        end
        3: begin
          w  = 18'd2;
          h  = 18'd2;
          xs = 18'd131072;
          ys = 18'd131072;
        end
        default: begin
          w  = 18'($urandom_range(2, 640));
          h  = 18'($urandom_range(2, 480));
          xs = 18'(131072 / (w - 1));
          ys = 18'(131072 / (h - 1));
        end
      endcase
      apply_setting(p[1:0], p[3:2], w, h, xs, ys);
      col_lim = (w[12:0] == 13'd0 || w[12:0] > 13'd4096) ? 4096 : int'(w[12:0]);
      row_lim = (h[12:0] == 13'd0 || h[12:0] > 13'd4096) ? 4096 : int'(h[12:0]);
      tx_idle_pct  = (p == 5 || p == 12) ? 0 : 34;
      rx_stall_pct = (p == 5 || p == 12) ? 0 : 34;
      for (int i = 0; i < 62; i++) begin
        if (p == 9 && i == 31) drain_results();
        if ($urandom_range(0, 9) == 0)
          push_pixel($urandom, 12'($urandom), 12'($urandom));
        else
          push_pixel($urandom, 12'($urandom_range(0, col_lim - 1)),
                     12'($urandom_range(0, row_lim - 1)));
      end
    end

    drain_results();
    repeat (PIPE_DEPTH + 8) @(negedge clk);
    if (fail_count == 0)
      $display("** crt_scanline_pixel_shader: PASSED **");
    else
      $display("** crt_scanline_pixel_shader: FAILED **");
    $finish;
  end

endmodule

[files.f]
sv/crtsh_pkg.sv
sv/crtsh_gain.sv
sv/crt_scanline_pixel_shader.sv
tb/crt_scanline_pixel_shader_checker.sv
tb/crt_scanline_pixel_shader_tb.sv
